// File: design/skte_pkg.sv
// ---------------------------------------------------------------------------
// skte_pkg: shared types and constants for the sorted key table
// Entry layout, status codes, compare unit modes and the value byte mask.
// ---------------------------------------------------------------------------
package skte_pkg;

  localparam int ENTRIES     = 64;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int COUNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W       = 64;
  localparam int VALUE_W     = 64;
  localparam int LEN_W       = 4;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 6;
  localparam int REMOVED_W   = 7;
  localparam int IN_W        = 168;
  localparam int OUT_W       = 152;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_NEXT   = 2'd2,
    OP_PURGE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_TOOBIG   = 3'd4,
    ST_NONEXT   = 3'd5
  } status_t;

  typedef enum logic {
    CMP_KEY = 1'b0,
    CMP_AGE = 1'b1
  } cmp_mode_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  stamp;
    logic [KEY_W-1:0]   key;
  } entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  // Keep the low n bytes of a word.
  function automatic logic [VALUE_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [VALUE_W-1:0] m;
    m = '0;
    for (int b = 0; b < VALUE_W / 8; b++) begin
      if (LEN_W'(b) < n) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask();
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) m[b*8 +: 8] = 8'hFF;
    return m;
  endfunction

endpackage

// File: design/skte_ram.sv
// ---------------------------------------------------------------------------
// skte_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module skte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: design/skte_unit.sv
// ---------------------------------------------------------------------------
// skte_unit: shared compare unit
// Compares a stored key against the request key, or an entry's expiry
// time (stamp plus lifetime, no wrap) against the current time.
// ---------------------------------------------------------------------------
module skte_unit (
  input  skte_pkg::cmp_mode_t              mode,
  input  logic [skte_pkg::KEY_W-1:0]       stored_key,
  input  logic [skte_pkg::KEY_W-1:0]       req_key,
  input  logic [skte_pkg::TIME_W-1:0]      stamp,
  input  logic [skte_pkg::TIME_W-1:0]      lifetime,
  input  logic [skte_pkg::TIME_W-1:0]      now,
  output skte_pkg::cmp_res_t               res
);
  import skte_pkg::*;

  logic [TIME_W:0] expiry;
  logic [KEY_W:0]  opa;
  logic [KEY_W:0]  opb;

  always_comb begin
    expiry = {1'b0, stamp} + {1'b0, lifetime};
    if (mode == CMP_AGE) begin
      opa = (KEY_W + 1)'(expiry);
      opb = (KEY_W + 1)'(now);
    end else begin
      opa = {1'b0, stored_key};
      opb = {1'b0, req_key};
    end
    res.lt = opa < opb;
    res.eq = opa == opb;
  end

endmodule

// File: design/sorted_key_table_with_expiry.sv
// ---------------------------------------------------------------------------
// sorted_key_table_with_expiry: sorted key table with binary search and purge
// Keeps up to ENTRIES entries in one RAM sorted by unsigned key; insert,
// lookup, next greater key and purge of expired entries.
// ---------------------------------------------------------------------------
// Channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: op, key, value, value_length, now
// m_*      | out | m_tvalid/m_tready  | m_tdata: status, position, found_key,
//          |     |                    |   found_value, found_length, removed_count
// cfg_*    | in  | cfg_valid/cfg_ready| cfg_data: lifetime_seconds
//
// Sequencing: each binary search step is a RAM read, then a compare. Insert
// then shifts each entry above the slot up with a read and a write, and
// writes the new entry; purge reads and compares every stored entry. All
// of these walks go through the one RAM.
// Reset empties the table (count to zero) and sets lifetime to 3600.
// A result waits in the output register; the next request is taken once the
// sequencer is idle, even while that result is still unclaimed.
// ---------------------------------------------------------------------------
module sorted_key_table_with_expiry (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // op[1:0], key[65:2], value[129:66], value_length[133:130], now[165:134]
  input  logic [skte_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[2:0], position[8:3], found_key[72:9], found_value[136:73],
  // found_length[140:137], removed_count[147:141]
  output logic [skte_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skte_pkg::TIME_W-1:0]   cfg_data
);
  import skte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_SHRD, S_SHWR, S_INSW, S_NRD, S_NGET,
    S_PRD, S_PCMP, S_DONE
  } state_t;

  state_t                state;
  op_t                   op;
  logic [KEY_W-1:0]      key;
  logic [VALUE_W-1:0]    value;
  logic [LEN_W-1:0]      vlen;
  logic [TIME_W-1:0]     now;
  logic [TIME_W-1:0]     lifetime;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    lo;
  logic [COUNT_W-1:0]    hi;
  logic [COUNT_W-1:0]    slot;
  logic [COUNT_W-1:0]    idx;
  logic [COUNT_W-1:0]    kept;
  logic [COUNT_W-1:0]    removed;
  status_t               status;
  logic [KEY_W-1:0]      found_key;
  logic [VALUE_W-1:0]    found_value;
  logic [LEN_W-1:0]      found_length;

  logic [COUNT_W-1:0]    mid;
  logic [COUNT_W-1:0]    mid_sum;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [IDX_W-1:0]      raddr;
  entry_t                wdata;
  entry_t                rdata;
  cmp_mode_t             mode;
  cmp_res_t              cmp;
  logic [$bits(entry_t)-1:0] rdata_raw;
  logic                  req_too_big;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign mid_sum   = lo + hi;
  assign mid       = {1'b0, mid_sum[COUNT_W-1:1]};
  assign rdata     = entry_t'(rdata_raw);
  assign mode      = (state == S_PCMP) ? CMP_AGE : CMP_KEY;
  // An insert with an oversize value is refused before any search.
  assign req_too_big = (op_t'(s_tdata[1:0]) == OP_INSERT) &&
                       (s_tdata[133:130] > LEN_W'(VALUE_BYTES));

  // RAM port selection per sequencer step.
  always_comb begin
    we    = 1'b0;
    waddr = idx[IDX_W-1:0];
    wdata = rdata;
    raddr = mid[IDX_W-1:0];
    unique case (state)
      S_SRD:  raddr = mid[IDX_W-1:0];
      S_SHRD: raddr = IDX_W'(idx - 1'b1);
      S_SHWR: begin
        we = 1'b1;
      end
      S_INSW: begin
        we          = 1'b1;
        waddr       = slot[IDX_W-1:0];
        wdata.key   = key;
        wdata.stamp = now;
        wdata.value = value;
        wdata.len   = vlen;
      end
      S_NRD:  raddr = slot[IDX_W-1:0];
      S_PRD:  raddr = idx[IDX_W-1:0];
      S_PCMP: begin
        we    = !cmp.lt;
        waddr = kept[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  skte_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  skte_unit u_unit (
    .mode       (mode),
    .stored_key (rdata.key),
    .req_key    (key),
    .stamp      (rdata.stamp),
    .lifetime   (lifetime),
    .now        (now),
    .res        (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      lifetime <= TIME_W'(3600);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) lifetime <= cfg_data;
      // Drop the result once taken, unless a new one loads this cycle.
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // Latch the request and clear the result fields.
            op           <= op_t'(s_tdata[1:0]);
            key          <= s_tdata[65:2] & key_mask();
            value        <= s_tdata[129:66] & byte_mask(s_tdata[133:130]);
            vlen         <= s_tdata[133:130];
            now          <= s_tdata[165:134];
            lo           <= '0;
            hi           <= count;
            slot         <= '0;
            idx          <= '0;
            kept         <= '0;
            removed      <= '0;
            status       <= req_too_big ? ST_TOOBIG : ST_OK;
            found_key    <= '0;
            found_value  <= '0;
            found_length <= '0;
            if (op_t'(s_tdata[1:0]) == OP_PURGE) begin
              state <= S_PRD;
            end else if (req_too_big) begin
              state <= S_DONE;
            end else begin
              state <= S_SRD;
            end
          end
        end

        // Issue a read at mid, or finish the search on an empty range.
        S_SRD: begin
          if (lo < hi) begin
            state <= S_SCMP;
          end else begin
            unique case (op)
              OP_INSERT: begin
                if (count >= COUNT_W'(ENTRIES)) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  slot  <= lo;
                  idx   <= count;
                  state <= S_SHRD;
                end
              end
              OP_LOOKUP: begin
                status <= ST_NOTFOUND;
                state  <= S_DONE;
              end
              default: begin
                slot  <= lo;
                state <= S_NRD;
              end
            endcase
          end
        end

        S_SCMP: begin
          if (cmp.eq) begin
            unique case (op)
              OP_INSERT: begin
                status <= ST_EXISTS;
                state  <= S_DONE;
              end
              OP_LOOKUP: begin
                slot         <= mid;
                found_value  <= rdata.value;
                found_length <= rdata.len;
                state        <= S_DONE;
              end
              default: begin
                slot  <= mid + 1'b1;
                state <= S_NRD;
              end
            endcase
          end else if (cmp.lt) begin
            lo    <= mid + 1'b1;
            state <= S_SRD;
          end else begin
            hi    <= mid;
            state <= S_SRD;
          end
        end

        // Shift entries above the slot up one place, top first.
        S_SHRD: begin
          state <= (idx > slot) ? S_SHWR : S_INSW;
        end

        S_SHWR: begin
          idx   <= idx - 1'b1;
          state <= S_SHRD;
        end

        S_INSW: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end

        S_NRD: begin
          if (slot < count) begin
            state <= S_NGET;
          end else begin
            slot   <= '0;
            status <= ST_NONEXT;
            state  <= S_DONE;
          end
        end

        S_NGET: begin
          found_key <= rdata.key;
          state     <= S_DONE;
        end

        // Walk the table, keep live entries packed at the bottom.
        S_PRD: begin
          if (idx < count) begin
            state <= S_PCMP;
          end else begin
            count <= kept;
            state <= S_DONE;
          end
        end

        S_PCMP: begin
          if (cmp.lt) removed <= removed + 1'b1;
          else        kept    <= kept + 1'b1;
          idx   <= idx + 1'b1;
          state <= S_PRD;
        end

        // Hold the result until the output register is free.
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, removed, found_length, found_value, found_key,
                         slot[POS_W-1:0], status};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRD || state == S_SCMP) |-> (lo <= hi && hi <= count))
    else $error("search range out of order");

  a_purge_tally: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRD) |-> (kept + removed == idx))
    else $error("purge tally does not match walk position");

  a_shift_above_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHWR) |-> (idx > slot && idx <= count))
    else $error("shift outside the open range");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSW) |-> (count < COUNT_W'(ENTRIES)))
    else $error("insert into a full table");

endmodule
